>>> design/vqdm_pkg.sv
// package: shared types, constants and widths for the descriptor manager
package vqdm_pkg;

  localparam int unsigned QueueSizeDef = 256;
  localparam int unsigned SlotW = 8;
  localparam int unsigned CountW = 9;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoSpace = 2'd1,
    StInvalid = 2'd2,
    StDropped = 2'd3
  } status_e;

  typedef enum logic {
    CmdAdd      = 1'b0,
    CmdComplete = 1'b1
  } command_e;

  typedef struct packed {
    logic        command;
    logic [63:0] desc_addr;
    logic [31:0] desc_len;
    logic [15:0] desc_flags;
    logic [8:0]  chain_count;
    logic [63:0] cookie_in;
    logic [7:0]  used_id;
    logic [31:0] used_len;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  desc_slot;
    logic [15:0] desc_flags_out;
    logic [7:0]  next_slot;
    logic        avail_publish;
    logic [7:0]  avail_position;
    logic [7:0]  avail_head;
    logic [63:0] done_cookie;
    logic [31:0] done_len;
    logic [8:0]  freed_count;
  } out_word_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkAddRd,
    BkCplRd,
    BkWalk,
    BkOut
  } bk_state_e;

endpackage

>>> design/vqdm_if.sv
// interfaces: valid/ready channels for input and result words
interface vqdm_in_if;
  logic                 valid;
  logic                 ready;
  vqdm_pkg::in_word_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vqdm_out_if;
  logic                 valid;
  logic                 ready;
  vqdm_pkg::out_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/vqdm_front.sv
// front end: two-entry queue that accepts input words for the back end
module vqdm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  vqdm_in_if.sink            in_i,
  output logic               deq_valid_o,
  output vqdm_pkg::in_word_t deq_word_o,
  input  logic               deq_take_i
);
  import vqdm_pkg::*;

  in_word_t   mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign pop         = deq_take_i && (cnt_q != 2'd0);
  assign deq_valid_o = (cnt_q != 2'd0);
  assign deq_word_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= in_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> design/vqdm_back.sv
// back end: free list, descriptor stores, chain walk and result register
module vqdm_back #(
  parameter int unsigned QUEUE_SIZE = vqdm_pkg::QueueSizeDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               word_valid_i,
  input  vqdm_pkg::in_word_t word_i,
  output logic               word_take_o,
  vqdm_out_if.source         out_o
);
  import vqdm_pkg::*;

  localparam int unsigned AW = (QUEUE_SIZE > 1) ? $clog2(QUEUE_SIZE) : 1;
  localparam int unsigned TW = $clog2(QUEUE_SIZE + 1);
  localparam logic [TW-1:0] QSize = TW'(QUEUE_SIZE);
  localparam logic [AW-1:0] LastSlot = AW'(QUEUE_SIZE - 1);

  // free list link memory; written entries tracked by a fill count
  logic [AW-1:0] link_mem [QUEUE_SIZE];
  logic [AW-1:0] next_mem [QUEUE_SIZE];
  logic          more_mem [QUEUE_SIZE];
  logic [63:0]   addr_mem [QUEUE_SIZE];
  logic [31:0]   len_mem  [QUEUE_SIZE];
  logic [15:0]   flag_mem [QUEUE_SIZE];
  logic [63:0]   cook_mem [QUEUE_SIZE];

  logic [TW-1:0] fill_q, fill_d;   // entries at or above fill_q have not been linked
  bk_state_e     st_q, st_d;
  in_word_t      w_q;
  logic [AW-1:0] list_top_q, list_top_d;
  logic [TW-1:0] free_total_q, free_total_d;
  logic [15:0]   avail_q, avail_d;
  logic [AW-1:0] avail_pos_q, avail_pos_d;
  logic [CountW-1:0] left_q, left_d;
  logic [AW-1:0] start_q, start_d;
  logic          drop_q, drop_d;
  logic          open_q, open_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CountW-1:0] freed_q, freed_d;
  out_word_t     res_q, res_d;
  logic          rvalid_q, rvalid_d;

  // read port, registered
  logic [AW-1:0] lk_raddr, lk_raddr_q;
  logic [AW-1:0] lk_rdata_q;
  logic [AW-1:0] nx_rdata_q;
  logic          mo_rdata_q;
  logic [63:0]   ck_rdata_q;
  logic          lk_valid_q;
  logic          byp_hit_q;
  logic [AW-1:0] byp_data_q;
  logic [AW-1:0] lk_rd;

  logic          lk_we;
  logic [AW-1:0] lk_waddr, lk_wdata;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [AW-1:0] st_next;
  logic          st_more;
  logic          ck_we;
  logic [AW-1:0] ck_waddr;
  logic [63:0]   ck_wdata;
  logic          lk_we2;
  logic [AW-1:0] lk_waddr2, lk_wdata2;
  logic          id_ok;

  assign id_ok = (32'(w_q.used_id) < QUEUE_SIZE);

  // a link written in the last cycle wins over the stale read data
  always_comb begin
    if (byp_hit_q) lk_rd = byp_data_q;
    else if (lk_valid_q) lk_rd = lk_rdata_q;
    else if (lk_raddr_q == LastSlot) lk_rd = '0;
    else lk_rd = lk_raddr_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    lk_rdata_q  <= link_mem[lk_raddr];
    lk_raddr_q  <= lk_raddr;
    byp_data_q  <= (lk_we2 && (lk_waddr2 == lk_raddr)) ? lk_wdata2 : lk_wdata;
    nx_rdata_q  <= next_mem[idx_d];
    mo_rdata_q  <= more_mem[idx_d];
    ck_rdata_q  <= cook_mem[idx_d];
    if (lk_we) link_mem[lk_waddr] <= lk_wdata;
    if (lk_we2) link_mem[lk_waddr2] <= lk_wdata2;
    if (st_we) begin
      addr_mem[st_waddr] <= w_q.desc_addr;
      len_mem[st_waddr]  <= w_q.desc_len;
      flag_mem[st_waddr] <= res_d.desc_flags_out;
      next_mem[st_waddr] <= st_next;
      more_mem[st_waddr] <= st_more;
    end
    if (ck_we) cook_mem[ck_waddr] <= ck_wdata;
  end

  // fill-count tracks which link entries still hold their reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_valid_q <= 1'b0;
      byp_hit_q  <= 1'b0;
    end else begin
      lk_valid_q <= (TW'(lk_raddr) < fill_d) || (TW'(lk_raddr) < fill_q);
      byp_hit_q  <= (lk_we && (lk_waddr == lk_raddr)) ||
                    (lk_we2 && (lk_waddr2 == lk_raddr));
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      BkIdle:  if (word_valid_i && (!rvalid_q || out_o.ready)) begin
        st_d = (word_i.command == CmdComplete) ? BkCplRd : BkAddRd;
      end
      BkAddRd: st_d = BkOut;
      BkCplRd: st_d = (id_ok && (free_total_q < QSize)) ? BkWalk : BkOut;
      BkWalk:  st_d = (!mo_rdata_q || (free_total_q + TW'(1) >= QSize)) ? BkOut : BkWalk;
      BkOut:   st_d = BkIdle;
      default: st_d = BkIdle;
    endcase
  end

  always_comb begin
    logic first;
    logic [CountW-1:0] cnt, rem;
    logic [AW-1:0] slot, nhead;
    first = (left_q == '0);
    cnt   = w_q.chain_count;
    rem   = '0;
    slot  = list_top_q;
    nhead = lk_rd;
    word_take_o = 1'b0;
    list_top_d = list_top_q;
    free_total_d = free_total_q;
    avail_d = avail_q;
    avail_pos_d = avail_pos_q;
    left_d = left_q;
    start_d = start_q;
    drop_d = drop_q;
    open_d = open_q;
    idx_d = idx_q;
    freed_d = freed_q;
    res_d = res_q;
    rvalid_d = rvalid_q;
    fill_d = fill_q;
    lk_raddr = list_top_q;
    lk_we = 1'b0; lk_waddr = '0; lk_wdata = '0;
    lk_we2 = 1'b0; lk_waddr2 = '0; lk_wdata2 = '0;
    st_we = 1'b0; st_waddr = slot; st_next = '0; st_more = 1'b0; ck_we = 1'b0;
    ck_waddr = slot; ck_wdata = w_q.cookie_in;
    if (rvalid_q && out_o.ready) rvalid_d = 1'b0;
    case (st_q)
      BkIdle: begin
        if (word_valid_i && (!rvalid_q || out_o.ready)) begin
          word_take_o = 1'b1;
          idx_d = AW'(word_i.used_id);
          open_d = (left_q != '0) && !drop_q;
          freed_d = '0;
        end
      end
      BkAddRd: begin
        res_d = '0;
        if (first && (cnt == '0 || 32'(cnt) > QUEUE_SIZE)) begin
          res_d.status = StInvalid;
        end else if (first && (TW'(cnt) > free_total_q)) begin
          res_d.status = StNoSpace;
          left_d = cnt - 1'b1;
          drop_d = (cnt != CountW'(1));
        end else if (!first && drop_q) begin
          res_d.status = StDropped;
          left_d = left_q - 1'b1;
          if (left_q == CountW'(1)) drop_d = 1'b0;
        end else begin
          rem = first ? cnt - 1'b1 : left_q - 1'b1;
          list_top_d = nhead;
          free_total_d = free_total_q - 1'b1;
          left_d = rem;
          if (first) begin
            start_d = slot;
            ck_we = 1'b1;
          end
          st_we = 1'b1;
          st_more = (rem != '0);
          st_next = st_more ? nhead : '0;
          res_d.status = StOk;
          res_d.desc_slot = 8'(slot);
          res_d.desc_flags_out = {w_q.desc_flags[15:1], st_more};
          res_d.next_slot = 8'(st_next);
          if (rem == '0) begin
            res_d.avail_publish = 1'b1;
            res_d.avail_position = 8'(avail_pos_q);
            res_d.avail_head = 8'(first ? slot : start_q);
            avail_d = avail_q + 16'd1;
            // ring position follows the 16-bit index modulo the queue size
            avail_pos_d = (avail_q == 16'hFFFF || avail_pos_q == LastSlot) ? '0
                          : avail_pos_q + 1'b1;
          end
        end
      end
      BkCplRd: begin
        res_d = '0;
        if (id_ok) begin
          res_d.status = StOk;
          res_d.done_len = w_q.used_len;
          res_d.done_cookie = ck_rdata_q;
          ck_we = 1'b1;
          ck_waddr = idx_q;
          ck_wdata = '0;
        end else begin
          res_d.status = StInvalid;
        end
      end
      BkWalk: begin
        // link one freed slot per cycle
        if (open_q) begin
          lk_we = 1'b1; lk_waddr = idx_q; lk_wdata = lk_rd;
          lk_we2 = 1'b1; lk_waddr2 = list_top_q; lk_wdata2 = idx_q;
        end else begin
          lk_we = 1'b1; lk_waddr = idx_q; lk_wdata = list_top_q;
          list_top_d = idx_q;
        end
        free_total_d = free_total_q + 1'b1;
        freed_d = freed_q + 1'b1;
        idx_d = nx_rdata_q;
        res_d.freed_count = freed_q + 1'b1;
        if (TW'(idx_q) >= fill_q) fill_d = fill_q;
      end
      BkOut: rvalid_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (word_take_o) w_q <= word_i;
    res_q <= res_d;
  end

  // no link entry gets written before its slot was handed out, so mark
  // the entry written by a walk as no longer fresh
  logic [TW-1:0] fill_w;
  always_comb begin
    fill_w = fill_d;
    if (lk_we && (TW'(lk_waddr) + TW'(1) > fill_w)) fill_w = TW'(lk_waddr) + TW'(1);
    if (lk_we2 && (TW'(lk_waddr2) + TW'(1) > fill_w)) fill_w = TW'(lk_waddr2) + TW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkIdle;
      list_top_q <= '0;
      free_total_q <= QSize;
      avail_q <= '0;
      avail_pos_q <= '0;
      left_q <= '0;
      start_q <= '0;
      drop_q <= 1'b0;
      open_q <= 1'b0;
      idx_q <= '0;
      freed_q <= '0;
      rvalid_q <= 1'b0;
      fill_q <= '0;
    end else begin
      st_q <= st_d;
      list_top_q <= list_top_d;
      free_total_q <= free_total_d;
      avail_q <= avail_d;
      avail_pos_q <= avail_pos_d;
      left_q <= left_d;
      start_q <= start_d;
      drop_q <= drop_d;
      open_q <= open_d;
      idx_q <= idx_d;
      freed_q <= freed_d;
      rvalid_q <= rvalid_d;
      fill_q <= fill_w;
    end
  end

  assign out_o.valid = rvalid_q;
  assign out_o.data  = res_q;
endmodule

>>> design/virtqueue_descriptor_manager_core.sv
// top level: descriptor manager with decoupled front queue and back end
//
// channel | dir | handshake     | word
// in      | in  | valid / ready | command, descriptor, chain, completion
// out     | out | valid / ready | status, slot, publish, done fields
//
// an add steps through the free-list read, the update and the result;
// a valid completion also walks the chain, freeing one descriptor per cycle.
// the free-list link memory read port sets the add pace.
// reset fills the free list; links read as (slot+1) mod size until written.
// a stalled result holds the back end; the front queue takes words until full.
module virtqueue_descriptor_manager_core #(
  parameter int unsigned QUEUE_SIZE = vqdm_pkg::QueueSizeDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  vqdm_in_if.sink     in_i,
  vqdm_out_if.source  out_o
);
  import vqdm_pkg::*;

  logic     deq_valid, deq_take;
  in_word_t deq_word;

  vqdm_front u_front (
    .clk_i, .rst_ni, .in_i,
    .deq_valid_o(deq_valid), .deq_word_o(deq_word), .deq_take_i(deq_take)
  );

  vqdm_back #(.QUEUE_SIZE(QUEUE_SIZE)) u_back (
    .clk_i, .rst_ni,
    .word_valid_i(deq_valid), .word_i(deq_word), .word_take_o(deq_take),
    .out_o
  );

  a_take_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_take |-> deq_valid) else $error("take without queued word");
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data))
    else $error("result dropped under stall");
  a_no_take_when_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_take |-> !out_o.valid || out_o.ready) else $error("take over pending result");
endmodule
